// File: hw/rtl/cfbdc_pkg.sv
package cfbdc_pkg;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_PARAM = 1'b1;

    // Fixed frame bytes.
    localparam logic [7:0] HDR_SYNC0 = 8'h58;
    localparam logic [7:0] HDR_SYNC1 = 8'h46;
    localparam logic [7:0] DATA_LEAD = 8'hF0;
    localparam logic [7:0] DATA_ZERO = 8'h00;

    // Header bytes plus lead bytes plus the data checksum.
    localparam logic [15:0] FRAME_EXTRA = 16'd10;

    // Longest run of bytes that one item can produce, and its counter width.
    localparam int MAX_RUN = 10;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);

    // Run lengths of the item kinds.
    localparam logic [RUN_W-1:0] RUN_START_OPEN  = RUN_W'(9);
    localparam logic [RUN_W-1:0] RUN_START_CLOSE = RUN_W'(10);
    localparam logic [RUN_W-1:0] RUN_PARAM_OPEN  = RUN_W'(1);
    localparam logic [RUN_W-1:0] RUN_PARAM_CLOSE = RUN_W'(2);

    typedef struct packed {
        logic        op;
        logic [7:0]  frame_index;
        logic [7:0]  command_code;
        logic [15:0] param_count;
        logic [7:0]  param_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_out_item;

    // Two's-complement negation mod 256 of a checksum sum.
    function automatic logic [7:0] neg8(input logic [7:0] s);
        neg8 = 8'(~s + 8'd1);
    endfunction

endpackage

// File: hw/rtl/command_frame_builder_dual_checksum_top.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// Each accepted item is turned into its run of frame bytes and held in a
// run register; the run drains one byte per cycle into the output register
// while the output is not stalled. A parameter item yields one byte (two
// when it closes the frame), a start item nine or ten. The next item is
// taken in the cycle the last byte of the current run leaves. Reset is
// synchronous, active low, and closes any open frame. A stalled output holds
// its byte, and the input stalls while a run is still draining.
module command_frame_builder_dual_checksum_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cfbdc_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cfbdc_pkg::t_out_item  o_out_data
);
    import cfbdc_pkg::*;

    // Frame state.
    logic              r_open;
    logic [15:0]       r_params_left;
    logic [7:0]        r_data_sum;
    logic              n_open;
    logic [15:0]       n_params_left;
    logic [7:0]        n_data_sum;

    // Run register: bytes still to send for the current item.
    logic              r_job_valid;
    logic [7:0]        r_job_bytes [MAX_RUN];
    logic [RUN_W-1:0]  r_job_left;
    logic              r_job_fe;
    logic [7:0]        n_job_bytes [MAX_RUN];
    logic [RUN_W-1:0]  n_job_len;
    logic              n_job_fe;

    // Output register.
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              out_take;
    logic              emit;
    logic              job_done;
    logic              in_accept;
    logic [15:0]       frame_len;
    logic [7:0]        hdr_sum;
    logic [7:0]        lead_sum;
    logic [7:0]        param_sum;
    logic [15:0]       param_left;

    // Handshake control.
    assign out_take   = !r_out_valid || !i_out_stall;
    assign emit       = r_job_valid && out_take;
    assign job_done   = emit && (r_job_left == RUN_W'(1));
    assign o_in_stall = r_job_valid && !job_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Sums used by the checksums and the length field.
    assign frame_len  = 16'(i_in_data.param_count + FRAME_EXTRA);
    assign hdr_sum    = 8'(HDR_SYNC0 + HDR_SYNC1 + frame_len[7:0] + frame_len[15:8]
                           + i_in_data.frame_index);
    assign lead_sum   = 8'(DATA_LEAD + i_in_data.command_code);
    assign param_sum  = 8'(r_data_sum + i_in_data.param_byte);
    assign param_left = 16'(r_params_left - 16'd1);

    // Build the run of bytes for the incoming item and the next frame state.
    always_comb begin
        for (int k = 0; k < MAX_RUN; k++) begin
            n_job_bytes[k] = 8'h00;
        end
        n_job_len     = '0;
        n_job_fe      = 1'b0;
        n_open        = r_open;
        n_params_left = r_params_left;
        n_data_sum    = r_data_sum;
        if (i_in_data.op == OP_START) begin
            n_job_bytes[0] = HDR_SYNC0;
            n_job_bytes[1] = HDR_SYNC1;
            n_job_bytes[2] = frame_len[7:0];
            n_job_bytes[3] = frame_len[15:8];
            n_job_bytes[4] = i_in_data.frame_index;
            n_job_bytes[5] = neg8(hdr_sum);
            n_job_bytes[6] = DATA_LEAD;
            n_job_bytes[7] = DATA_ZERO;
            n_job_bytes[8] = i_in_data.command_code;
            n_data_sum     = lead_sum;
            if (i_in_data.param_count == 16'd0) begin
                n_job_bytes[9] = neg8(lead_sum);
                n_job_len      = RUN_START_CLOSE;
                n_job_fe       = 1'b1;
                n_open         = 1'b0;
                n_params_left  = 16'd0;
            end else begin
                n_job_len     = RUN_START_OPEN;
                n_open        = 1'b1;
                n_params_left = i_in_data.param_count;
            end
        end else if (r_open) begin
            // A parameter outside an open frame produces nothing.
            n_job_bytes[0] = i_in_data.param_byte;
            n_data_sum     = param_sum;
            n_params_left  = param_left;
            if (param_left == 16'd0) begin
                n_job_bytes[1] = neg8(param_sum);
                n_job_len      = RUN_PARAM_CLOSE;
                n_job_fe       = 1'b1;
                n_open         = 1'b0;
            end else begin
                n_job_len = RUN_PARAM_OPEN;
            end
        end
    end

    // Frame state update on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open        <= 1'b0;
            r_params_left <= 16'd0;
            r_data_sum    <= 8'd0;
        end else if (in_accept) begin
            r_open        <= n_open;
            r_params_left <= n_params_left;
            r_data_sum    <= n_data_sum;
        end
    end

    // Run register control: load a new run, or count down as bytes leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_left  <= '0;
        end else if (in_accept && (n_job_len != '0)) begin
            r_job_valid <= 1'b1;
            r_job_left  <= n_job_len;
        end else if (emit) begin
            r_job_valid <= !job_done;
            r_job_left  <= RUN_W'(r_job_left - RUN_W'(1));
        end
    end

    // Run register payload: shift toward the head as bytes leave.
    always_ff @(posedge i_clk) begin
        if (in_accept && (n_job_len != '0)) begin
            r_job_bytes <= n_job_bytes;
            r_job_fe    <= n_job_fe;
        end else if (emit) begin
            for (int k = 0; k < MAX_RUN - 1; k++) begin
                r_job_bytes[k] <= r_job_bytes[k + 1];
            end
        end
    end

    // Output register: take the head byte whenever the output can move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.out_byte  <= r_job_bytes[0];
            r_out_data.run_last  <= (r_job_left == RUN_W'(1));
            r_out_data.frame_end <= (r_job_left == RUN_W'(1)) && r_job_fe;
        end
    end

endmodule
